[rtl/cwbq_pkg.sv]
`timescale 1ns / 1ps

package cwbq_pkg;

    localparam int DEPTH      = 16;
    localparam int KEY_WIDTH  = 32;
    localparam int DATA_WIDTH = 64;
    localparam int IDX_W      = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    typedef logic [KEY_WIDTH-1:0]  key_t;
    typedef logic [DATA_WIDTH-1:0] data_t;
    typedef logic [IDX_W-1:0]      idx_t;
    typedef logic [CNT_W-1:0]      cnt_t;

    typedef enum logic [1:0] {
        MODE_QUEUE   = 2'd0,
        MODE_ENFORCE = 2'd1,
        MODE_REMOVE  = 2'd2,
        MODE_FLUSH   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef struct packed {
        mode_t mode;
        key_t  key;
        data_t payload;
    } req_t;

    typedef struct packed {
        logic    writes_back;
        key_t    out_key;
        data_t   out_payload;
        status_t status;
        logic    last;
    } result_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_EXEC,
        S_FLUSH
    } ctrl_state_t;

    typedef struct packed {
        logic latch;
        logic lookup;
        logic exec;
        logic flush_step;
    } dp_cmd_t;

    typedef struct packed {
        logic is_flush;
        logic empty;
        logic one_left;
        logic out_free;
    } dp_status_t;

endpackage

[rtl/cwbq_ctrl.sv]
`timescale 1ns / 1ps

module cwbq_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  cwbq_pkg::dp_status_t   dp_status,
    output cwbq_pkg::dp_cmd_t      dp_cmd
);
    import cwbq_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        flush_busy;

    // flush of a non-empty buffer walks the entries in its own state
    assign flush_busy = dp_status.is_flush && !dp_status.empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) state_next = S_LOOKUP;
            end
            S_LOOKUP: begin
                state_next = S_EXEC;
            end
            S_EXEC: begin
                if (flush_busy) begin
                    state_next = S_FLUSH;
                end else if (dp_status.out_free) begin
                    state_next = S_IDLE;
                end
            end
            S_FLUSH: begin
                if (dp_status.out_free && dp_status.one_left) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_ready           = (state_reg == S_IDLE);
        dp_cmd.latch      = (state_reg == S_IDLE) && s_valid;
        dp_cmd.lookup     = (state_reg == S_LOOKUP);
        dp_cmd.exec       = (state_reg == S_EXEC) && dp_status.out_free && !flush_busy;
        dp_cmd.flush_step = (state_reg == S_FLUSH) && dp_status.out_free;
    end

endmodule

[rtl/cwbq_datapath.sv]
`timescale 1ns / 1ps

module cwbq_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cwbq_pkg::dp_cmd_t    dp_cmd,
    output cwbq_pkg::dp_status_t dp_status,
    input  cwbq_pkg::req_t       s_req,
    output logic                 m_valid,
    input  logic                 m_ready,
    output cwbq_pkg::result_t    m_result
);
    import cwbq_pkg::*;

    req_t    req_reg;
    key_t    key_mem_reg  [DEPTH];
    data_t   data_mem_reg [DEPTH];
    cnt_t    count_reg;
    cnt_t    count_next;
    idx_t    pos_reg;
    logic    found_reg;
    logic    m_valid_reg;
    result_t result_reg;

    idx_t    match_pos;
    logic    match_found;
    logic    full;
    logic    shift_en;
    idx_t    shift_pos;
    logic    wr_en;
    idx_t    wr_idx;
    logic    out_load;
    result_t out_next;

    assign full = (count_reg == cnt_t'(DEPTH));

    assign dp_status.is_flush = (req_reg.mode == MODE_FLUSH);
    assign dp_status.empty    = (count_reg == '0);
    assign dp_status.one_left = (count_reg == cnt_t'(1));
    assign dp_status.out_free = !m_valid_reg || m_ready;

    // compare against every live entry, lowest (oldest) match wins
    always_comb begin
        match_found = 1'b0;
        match_pos   = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (cnt_t'(i) < count_reg && key_mem_reg[i] == req_reg.key) begin
                match_found = 1'b1;
                match_pos   = idx_t'(i);
            end
        end
    end

    always_comb begin
        shift_en   = 1'b0;
        shift_pos  = pos_reg;
        wr_en      = 1'b0;
        wr_idx     = count_reg[IDX_W-1:0];
        count_next = count_reg;
        out_load   = 1'b0;
        out_next   = '0;
        out_next.status = ST_OK;
        out_next.last   = 1'b1;
        if (dp_cmd.exec) begin
            out_load = 1'b1;
            unique case (req_reg.mode)
                MODE_QUEUE: begin
                    if (found_reg) begin
                        // close the gap, then rewrite the new tail slot
                        shift_en = 1'b1;
                        wr_en    = 1'b1;
                        wr_idx   = idx_t'(count_reg - cnt_t'(1));
                    end else if (full) begin
                        out_next.status = ST_FULL;
                    end else begin
                        wr_en      = 1'b1;
                        count_next = count_reg + cnt_t'(1);
                    end
                end
                MODE_ENFORCE: begin
                    if (found_reg) begin
                        out_next.writes_back = 1'b1;
                        out_next.out_key     = key_mem_reg[pos_reg];
                        out_next.out_payload = data_mem_reg[pos_reg];
                        shift_en             = 1'b1;
                        count_next           = count_reg - cnt_t'(1);
                    end else begin
                        out_next.status = ST_NOT_FOUND;
                    end
                end
                MODE_REMOVE: begin
                    if (found_reg) begin
                        shift_en   = 1'b1;
                        count_next = count_reg - cnt_t'(1);
                    end else begin
                        out_next.status = ST_NOT_FOUND;
                    end
                end
                MODE_FLUSH: begin
                    // empty buffer: lone ok result
                end
                default: begin
                end
            endcase
        end else if (dp_cmd.flush_step) begin
            out_load             = 1'b1;
            out_next.writes_back = 1'b1;
            out_next.out_key     = key_mem_reg[0];
            out_next.out_payload = data_mem_reg[0];
            out_next.last        = (count_reg == cnt_t'(1));
            shift_en             = 1'b1;
            shift_pos            = '0;
            count_next           = count_reg - cnt_t'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (dp_cmd.latch) req_reg <= s_req;
        if (dp_cmd.lookup) begin
            pos_reg   <= match_pos;
            found_reg <= match_found;
        end
        if (out_load) result_reg <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_entry
            if (g < DEPTH - 1) begin : g_shift
                always_ff @(posedge aclk) begin
                    if (wr_en && wr_idx == idx_t'(g)) begin
                        key_mem_reg[g]  <= req_reg.key;
                        data_mem_reg[g] <= req_reg.payload;
                    end else if (shift_en && idx_t'(g) >= shift_pos) begin
                        key_mem_reg[g]  <= key_mem_reg[g+1];
                        data_mem_reg[g] <= data_mem_reg[g+1];
                    end
                end
            end else begin : g_tail
                always_ff @(posedge aclk) begin
                    if (wr_en && wr_idx == idx_t'(g)) begin
                        key_mem_reg[g]  <= req_reg.key;
                        data_mem_reg[g] <= req_reg.payload;
                    end
                end
            end
        end
    endgenerate

    assign m_valid  = m_valid_reg;
    assign m_result = result_reg;

endmodule

[rtl/coalescing_write_back_queue_core.sv]
`timescale 1ns / 1ps
// Coalescing write-back queue: ordered buffer of up to 16 pending writes.
// Input channel (s_valid/s_ready/s_req) takes one request: queue, enforce,
// remove or flush, with a key and a data word.
// Result channel (m_valid/m_ready/m_result) returns one result per request,
// or one write-back per stored entry for a flush of a non-empty buffer,
// oldest first, with last set on the final one.
// A request is accepted in the idle state, its key is compared against all
// entries in the cycle after, and the execute state then registers the result
// once the output register is free. A flush of a non-empty buffer moves on
// from the execute state to a flush state that registers one write-back per
// cycle from the head of the buffer while the output register is free. A new
// request is taken only once the block is back in idle; entries are compacted
// by a one-step shift of the entry registers.
// The result sits in an output register; s_ready does not depend on m_ready
// but the block holds in its execute state while that register is full and
// not taken, so a stalled receiver stalls the next request.
// Reset (aresetn low, synchronous) empties the buffer and drops any pending
// result; entry contents are not cleared.

module coalescing_write_back_queue_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  cwbq_pkg::req_t    s_req,
    output logic              m_valid,
    input  logic              m_ready,
    output cwbq_pkg::result_t m_result
);
    import cwbq_pkg::*;

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    cwbq_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .dp_status (dp_status),
        .dp_cmd    (dp_cmd)
    );

    cwbq_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .dp_cmd    (dp_cmd),
        .dp_status (dp_status),
        .s_req     (s_req),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_result  (m_result)
    );

endmodule
